/* hdl/per_source_rate_limiter_macros.svh */
// ----------------------------------------------------------------------------
// per_source_rate_limiter_macros
// Assertion macros used by the checker of the per-source rate limiter.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_RATE_LIMITER_MACROS_SVH
`define PER_SOURCE_RATE_LIMITER_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define PRSL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("per_source_rate_limiter: check failed");

// Check a consequence in the cycle after its antecedent.
`define PRSL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("per_source_rate_limiter: check failed");

`endif

/* hdl/prsl_pkg.sv */
// ----------------------------------------------------------------------------
// prsl_pkg
// Shared types and codes of the per-source rate limiter.
// ----------------------------------------------------------------------------
package prsl_pkg;

	localparam int IP_W      = 32;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int LIMIT_W   = 8;
	localparam int WINDOW_W  = 31;
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'b1;

	localparam logic [LIMIT_W-1:0]  RATE_LIMIT_RESET = 8'd0;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 31'd60000;

	// Verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_COUNTED  = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_DISABLED = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_FULL     = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_DENIED   = 2'd3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// One tracked source
	typedef struct packed {
		logic [IP_W-1:0]    address;
		logic [TIME_W-1:0]  window_start;
		logic [COUNT_W-1:0] requests;
	} entry_t;

endpackage

/* hdl/prsl_table.sv */
// ----------------------------------------------------------------------------
// prsl_table
// Source table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module prsl_table #(
	parameter int ENTRIES = 16
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx,
	output prsl_pkg::entry_t                       rd_entry,
	input  logic                                   wr_en,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
	input  prsl_pkg::entry_t                       wr_entry
);
	import prsl_pkg::*;

	entry_t mem_q [ENTRIES];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_entry;
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem_q[rd_idx];
		end
	end

endmodule

/* hdl/per_source_rate_limiter.sv */
// ----------------------------------------------------------------------------
// per_source_rate_limiter
// Fixed-window request limiter that tracks each source address in a small
// table, scanned one entry per cycle through a shared subtract/compare unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid / in_ready   | source_ip, now_ms
//  out      | output    | out_valid / out_ready | allowed, verdict, request_count
//  cfg      | input     | cfg_wr_en             | cfg_index, cfg_data
//
// The block takes one item at a time from accept to result: the
// table scan reads one entry per cycle from the single read port, then the
// update state writes back. With limiting disabled an item skips the scan.
// The update state waits while an earlier result is still held on the output.
// Reset clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_source_rate_limiter #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [prsl_pkg::IP_W-1:0]             source_ip,
	input  logic [prsl_pkg::TIME_W-1:0]           now_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  allowed,
	output logic [prsl_pkg::VERDICT_W-1:0]        verdict,
	output logic [prsl_pkg::COUNT_W-1:0]          request_count,
	input  logic                                  cfg_wr_en,
	input  logic [prsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [prsl_pkg::WINDOW_W-1:0]         cfg_data
);
	import prsl_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [LIMIT_W-1:0]     rate_q;
	logic [WINDOW_W-1:0]    window_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [IP_W-1:0]        ip_q;
	logic [TIME_W-1:0]      now_q;
	logic                   bypass_q;
	logic [CW-1:0]          cnt_q;
	logic                   eval_s1;
	logic [IW-1:0]          idx_s1;

	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [TIME_W-1:0]      hit_start_q;
	logic [COUNT_W-1:0]     hit_cnt_q;
	logic                   free_q;
	logic [IW-1:0]          free_idx_q;

	logic                   out_valid_q;
	logic                   allowed_q;
	logic [VERDICT_W-1:0]   verdict_q;
	logic [COUNT_W-1:0]     count_q;

	entry_t                 rd_entry;
	entry_t                 wr_entry;
	logic                   wr_en;
	logic [IW-1:0]          wr_idx;
	logic                   rd_en;

	logic                   accept;
	logic                   issue;
	logic                   slot_free;
	logic [TIME_W-1:0]      alu_opnd;
	logic [TIME_W-1:0]      alu_thr;
	logic [TIME_W-1:0]      alu_diff;
	logic                   alu_gt;
	logic                   alu_eq;
	logic                   ent_valid;
	logic                   ent_live;
	logic                   ent_match;
	logic                   restart;
	logic                   track;
	logic [COUNT_W-1:0]     base_cnt;
	logic [COUNT_W-1:0]     new_cnt;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_SCAN) && (cnt_q < LAST_CNT);
	assign slot_free = !out_valid_q || out_ready;

	// Shared unit: wrapping age against span (scan) or window (update)
	assign alu_opnd = (state_q == ST_SCAN) ? rd_entry.window_start : hit_start_q;
	assign alu_thr  = (state_q == ST_SCAN) ? {window_q, 1'b0} : {1'b0, window_q};
	assign alu_diff = now_q - alu_opnd;
	assign alu_gt   = alu_diff > alu_thr;
	assign alu_eq   = alu_diff == alu_thr;

	// Classify the entry coming out of the read port
	assign ent_valid = eval_s1 && valid_q[idx_s1];
	assign ent_live  = ent_valid && !(alu_gt || alu_eq);
	assign ent_match = ent_live && (rd_entry.address == ip_q);

	// Count for the tracked source
	assign restart  = alu_gt;
	assign track    = hit_q || free_q;
	assign base_cnt = (hit_q && !restart) ? hit_cnt_q : '0;
	assign new_cnt  = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + COUNT_W'(1);

	// Table ports
	assign rd_en  = issue;
	assign wr_en  = (state_q == ST_UPDATE) && slot_free && !bypass_q && track;
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;
	always_comb begin
		wr_entry.address      = ip_q;
		wr_entry.window_start = (hit_q && !restart) ? hit_start_q : now_q;
		wr_entry.requests     = new_cnt;
	end

	prsl_table #(
		.ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_idx   (cnt_q[IW-1:0]),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_LIMIT_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RATE_LIMIT:   rate_q   <= cfg_data[LIMIT_W-1:0];
				CFG_WINDOW_TICKS: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequence one item: accept, scan (skipped with limiting disabled), update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			eval_s1 <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			bypass_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q    <= '0;
						eval_s1  <= 1'b0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						bypass_q <= (rate_q == '0);
						state_q  <= (rate_q == '0) ? ST_UPDATE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					eval_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_UPDATE;
					end
					if (ent_match) begin
						hit_q <= 1'b1;
					end
					if (eval_s1 && !ent_live && !free_q) begin
						free_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance scan stage and capture hit and first free slot
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			ip_q  <= source_ip;
			now_q <= now_ms;
		end
		if (ent_match) begin
			hit_idx_q   <= idx_s1;
			hit_start_q <= rd_entry.window_start;
			hit_cnt_q   <= rd_entry.requests;
		end
		if ((state_q == ST_SCAN) && eval_s1 && !ent_live && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Drop stale entries during the scan, mark allocated entries at update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if ((state_q == ST_SCAN) && ent_valid && !ent_live) begin
			valid_q[idx_s1] <= 1'b0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_UPDATE) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && slot_free) begin
			if (bypass_q) begin
				allowed_q <= 1'b1;
				verdict_q <= VERDICT_DISABLED;
				count_q   <= '0;
			end else if (!track) begin
				allowed_q <= 1'b1;
				verdict_q <= VERDICT_FULL;
				count_q   <= '0;
			end else if (new_cnt > {{(COUNT_W-LIMIT_W){1'b0}}, rate_q}) begin
				allowed_q <= 1'b0;
				verdict_q <= VERDICT_DENIED;
				count_q   <= new_cnt;
			end else begin
				allowed_q <= 1'b1;
				verdict_q <= VERDICT_COUNTED;
				count_q   <= new_cnt;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign allowed       = allowed_q;
	assign verdict       = verdict_q;
	assign request_count = count_q;

endmodule

/* hdl/prsl_checker.sv */
// ----------------------------------------------------------------------------
// prsl_checker
// Port-level checks of the per-source rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_source_rate_limiter_macros.svh"

module prsl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           allowed,
	input logic [prsl_pkg::VERDICT_W-1:0] verdict,
	input logic [prsl_pkg::COUNT_W-1:0]   request_count
);
	import prsl_pkg::*;

	// Hold a stalled result
	`PRSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(allowed) && $stable(verdict) && $stable(request_count))

	// Refuse exactly the denied items
	`PRSL_ASSERT_NOW(a_allowed_verdict, clk, arst_n, out_valid, allowed == (verdict != VERDICT_DENIED))

	// Report zero for untracked items
	`PRSL_ASSERT_NOW(a_untracked_zero, clk, arst_n, out_valid && (verdict == VERDICT_DISABLED || verdict == VERDICT_FULL), request_count == '0)

	// Report a nonzero count for tracked items
	`PRSL_ASSERT_NOW(a_tracked_count, clk, arst_n, out_valid && (verdict == VERDICT_COUNTED || verdict == VERDICT_DENIED), request_count != '0)

	// Work on one item at a time
	`PRSL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind per_source_rate_limiter prsl_checker u_prsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.allowed       (allowed),
	.verdict       (verdict),
	.request_count (request_count)
);

/* tb/tb_per_source_rate_limiter.sv */
// ----------------------------------------------------------------------------
// tb_per_source_rate_limiter
// Drives requests into the per-source rate limiter with random gaps and
// output back-pressure, predicts each verdict from a table model kept in
// the bench, and compares every result field. Directed requests cover
// window wrap, window edges, table full and stale cleanup. A burst to one
// source runs with no idling on either side. Random phases then run
// under several limit and window settings.
// ----------------------------------------------------------------------------
module tb_per_source_rate_limiter;
	import prsl_pkg::*;

	localparam int TB_ENTRIES     = 16;
	localparam int SETTLE_CYCLES  = 40;
	localparam int CYCLE_LIMIT    = 4000000;
	localparam int BURST_REQUESTS = 40;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [TIME_W-1:0] stamp;
	} request_t;

	typedef struct packed {
		logic                 allowed;
		logic [VERDICT_W-1:0] code;
		logic [COUNT_W-1:0]   hits;
	} verdict_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [IP_W-1:0]      source_ip     = '0;
	logic [TIME_W-1:0]    now_ms        = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 allowed;
	logic [VERDICT_W-1:0] verdict;
	logic [COUNT_W-1:0]   request_count;
	logic                 cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [WINDOW_W-1:0]  cfg_data      = '0;

	// Request and verdict queues, progress counters
	request_t req_queue[$];
	verdict_t verdict_fifo[$];
	int       issued     = 0;
	int       checked    = 0;
	int       fail_count = 0;
	int       cycles     = 0;
	bit       no_idle    = 1'b0;

	// Limiter model: configuration and source table
	logic [LIMIT_W-1:0]  lim_cfg = RATE_LIMIT_RESET;
	logic [WINDOW_W-1:0] win_cfg = WINDOW_RESET;
	logic                src_valid[TB_ENTRIES];
	logic [IP_W-1:0]     src_addr[TB_ENTRIES];
	logic [TIME_W-1:0]   src_start[TB_ENTRIES];
	logic [COUNT_W-1:0]  src_hits[TB_ENTRIES];

	per_source_rate_limiter #(
		.TABLE_ENTRIES(TB_ENTRIES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_ip    (source_ip),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.allowed      (allowed),
		.verdict      (verdict),
		.request_count(request_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predict the verdict of one request and update the source table
	function automatic verdict_t predict_verdict(input logic [IP_W-1:0] ip,
			input logic [TIME_W-1:0] stamp);
		verdict_t           res;
		logic [TIME_W-1:0]  span;
		logic [TIME_W-1:0]  age;
		logic [COUNT_W-1:0] hits;
		int                 slot;
		res.allowed = 1'b1;
		res.code    = VERDICT_DISABLED;
		res.hits    = '0;
		if (lim_cfg == '0)
			return res;
		// free sources whose window began two windows ago or earlier
		span = {win_cfg, 1'b0};
		for (int k = 0; k < TB_ENTRIES; k++) begin
			age = stamp - src_start[k];
			if (src_valid[k] && age >= span)
				src_valid[k] = 1'b0;
		end
		slot = -1;
		for (int k = 0; k < TB_ENTRIES; k++)
			if (slot < 0 && src_valid[k] && src_addr[k] == ip)
				slot = k;
		for (int k = 0; k < TB_ENTRIES; k++) begin
			if (slot < 0 && !src_valid[k]) begin
				slot         = k;
				src_valid[k] = 1'b1;
				src_addr[k]  = ip;
				src_start[k] = stamp;
				src_hits[k]  = '0;
			end
		end
		if (slot < 0) begin
			res.code = VERDICT_FULL;
			return res;
		end
		// restart an expired window, then count with saturation
		age = stamp - src_start[slot];
		if (age > {1'b0, win_cfg}) begin
			src_start[slot] = stamp;
			src_hits[slot]  = '0;
		end
		hits = src_hits[slot];
		if (hits != COUNT_MAX)
			hits = hits + 1'b1;
		src_hits[slot] = hits;
		res.hits = hits;
		if (hits > {{(COUNT_W-LIMIT_W){1'b0}}, lim_cfg}) begin
			res.allowed = 1'b0;
			res.code    = VERDICT_DENIED;
		end else begin
			res.code = VERDICT_COUNTED;
		end
		return res;
	endfunction

	// Driver: predict on accept, then present the next item or idle
	always @(posedge clk) begin : drive
		request_t req;
		if (in_valid && in_ready)
			verdict_fifo.push_back(predict_verdict(source_ip, now_ms));
		if (!in_valid || in_ready) begin
			if (req_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
				req = req_queue.pop_front();
				in_valid  <= 1'b1;
				source_ip <= req.ip;
				now_ms    <= req.stamp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall at random, check each accepted result
	always @(posedge clk) begin : watch
		verdict_t want;
		out_ready <= no_idle || ($urandom_range(0, 99) >= 15);
		if (out_valid && out_ready) begin
			if (verdict_fifo.size() == 0) begin
				$error("result with no request waiting: allowed %0d verdict %0d count %0d",
					allowed, verdict, request_count);
				fail_count++;
			end else begin
				want = verdict_fifo.pop_front();
				if (allowed !== want.allowed) begin
					$error("allowed: expected %0d, got %0d", want.allowed, allowed);
					fail_count++;
				end
				if (verdict !== want.code) begin
					$error("verdict: expected %0d, got %0d", want.code, verdict);
					fail_count++;
				end
				if (request_count !== want.hits) begin
					$error("request_count: expected %0d, got %0d", want.hits, request_count);
					fail_count++;
				end
				checked++;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_per_source_rate_limiter NOT OK");
			$finish;
		end
	end

	task automatic push_request(input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] stamp);
		request_t req;
		req.ip    = ip;
		req.stamp = stamp;
		req_queue.push_back(req);
		issued++;
	endtask

	// Wait until every issued item has its result, then let the block settle
	task automatic wait_drained();
		do @(posedge clk); while (checked != issued);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WINDOW_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_RATE_LIMIT)
			lim_cfg = data[LIMIT_W-1:0];
		else
			win_cfg = data;
	endtask

	// Write both registers; fill the unused bits of the limit write at random
	task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic [WINDOW_W-1:0] window);
		logic [31:0] junk;
		junk = $urandom;
		wait_drained();
		write_reg(CFG_RATE_LIMIT, {junk[WINDOW_W-LIMIT_W-1:0], limit});
		write_reg(CFG_WINDOW_TICKS, window);
	endtask

	// Random traffic: a pool of sources, time advancing in steps of the window
	task automatic run_phase(input logic [LIMIT_W-1:0] limit, input logic [WINDOW_W-1:0] window,
			input int reqs);
		logic [IP_W-1:0]   pool[24];
		logic [IP_W-1:0]   ip;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] hint;
		int                n;
		int                r;
		set_config(limit, window);
		n = $urandom_range(4, 24);
		for (int k = 0; k < n; k++)
			pool[k] = $urandom;
		t    = $urandom;
		hint = {4'd0, window[WINDOW_W-1:3]} + 32'd1;
		for (int i = 0; i < reqs; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				ip = $urandom;
				t  = $urandom;
			end else begin
				ip = pool[$urandom_range(0, $urandom_range(0, n - 1))];
				if (r < 25)
					t = t;
				else if (r < 32)
					t = t + $urandom_range(0, {window, 1'b1});
				else
					t = t + $urandom_range(0, hint);
			end
			push_request(ip, t);
		end
	endtask

	initial begin : stimulus
		for (int k = 0; k < TB_ENTRIES; k++) begin
			src_valid[k] = 1'b0;
			src_addr[k]  = '0;
			src_start[k] = '0;
			src_hits[k]  = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// limiting disabled after reset, field extremes
		push_request(32'h0000_0000, 32'h0000_0000);
		push_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(32'h8000_0001, 32'h7FFF_FFFE);

		// one source across the time wrap and both window edges
		set_config(8'd2, 31'd100);
		push_request(32'hC0A8_0001, 32'hFFFF_FFF0);
		push_request(32'hC0A8_0001, 32'hFFFF_FFF5);
		push_request(32'hC0A8_0001, 32'h0000_0010);
		push_request(32'hC0A8_0001, 32'h0000_0054);
		push_request(32'hC0A8_0001, 32'h0000_0055);

		// fill the table, overflow it, then free everything at two windows
		for (int k = 1; k < TB_ENTRIES; k++)
			push_request(32'h0A00_0000 + k, 32'h0000_0060);
		push_request(32'hFFFF_FFFF, 32'h0000_0061);
		push_request(32'h0000_0000, 32'h0000_0061);
		push_request(32'hFFFF_FFFF, 32'h0000_0128);

		// hold one source in a huge window for a burst with no idling
		set_config(8'd255, 31'h7FFF_FFFF);
		no_idle = 1'b1;
		for (int i = 0; i < BURST_REQUESTS; i++)
			push_request(32'h5A5A_A5A5, 32'h0000_0200);
		wait_drained();
		no_idle = 1'b0;

		run_phase(8'd1,   31'd0,          40);
		run_phase(8'd1,   31'd1,          100);
		run_phase(8'd255, 31'h7FFF_FFFF,  100);
		run_phase(8'd3,   31'd50,         140);
		run_phase(8'd0,   31'd60000,      60);
		run_phase(8'd2,   31'd1000,       140);
		run_phase(8'd5,   31'd200,        140);
		run_phase(8'd4,   31'h4000_0000,  100);
		run_phase(8'd1,   31'd60000,      90);

		wait_drained();
		if (fail_count == 0 && verdict_fifo.size() == 0)
			$display("tb_per_source_rate_limiter OK");
		else
			$display("tb_per_source_rate_limiter NOT OK");
		$finish;
	end

endmodule
